[rtl/signed_int_to_decimal_ascii_macros.svh]
// Assertion macros shared by the checker.
// Each expects clk and rst_n in the calling scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication.
`define SITODA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitoda check failed");

// Next-cycle implication.
`define SITODA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitoda check failed");

`endif

[rtl/sitoda_pkg.sv]
package sitoda_pkg;

    localparam int DEC_DIGIT_BITS = 4;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } sitoda_state_t;

    // Commands from the sequencer to the digit datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic dshift;
    } sitoda_ctl_t;

    // Decimal digits of 2^(bits-1); 1233/4096 approximates log10(2)
    function automatic int dec_digits(input int bits);
        return (((bits - 1) * 1233) >> 12) + 1;
    endfunction

endpackage

[rtl/sitoda_in_if.sv]
interface sitoda_in_if #(
    parameter int DATA_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[rtl/sitoda_out_if.sv]
interface sitoda_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

[rtl/sitoda_bcd.sv]
module sitoda_bcd
    import sitoda_pkg::*;
#(
    parameter int DATA_BITS = 32
)
(
    input  logic                      clk,
    input  sitoda_ctl_t               ctl,
    input  logic [DATA_BITS-1:0]      mag,
    output logic [DEC_DIGIT_BITS-1:0] top_digit
);

    localparam int NDIG  = dec_digits(DATA_BITS);
    localparam int BCD_W = NDIG * DEC_DIGIT_BITS;

    logic [DATA_BITS-1:0] mag_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     adj;

    // add-3 correction on every digit before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*DEC_DIGIT_BITS +: DEC_DIGIT_BITS] >= 4'd5)
                adj[i*DEC_DIGIT_BITS +: DEC_DIGIT_BITS] =
                    bcd_reg[i*DEC_DIGIT_BITS +: DEC_DIGIT_BITS] + 4'd3;
            else
                adj[i*DEC_DIGIT_BITS +: DEC_DIGIT_BITS] =
                    bcd_reg[i*DEC_DIGIT_BITS +: DEC_DIGIT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mag_reg <= mag;
            bcd_reg <= '0;
        end
        else if (ctl.dabble)
        begin
            mag_reg <= {mag_reg[DATA_BITS-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], mag_reg[DATA_BITS-1]};
        end
        else if (ctl.dshift)
        begin
            bcd_reg <= {bcd_reg[BCD_W-DEC_DIGIT_BITS-1:0], {DEC_DIGIT_BITS{1'b0}}};
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: DEC_DIGIT_BITS];

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Sequence: accept, shift-add-3 over all DATA_BITS input bits in the BCD unit,
// skip of leading zeros, a minus sign for a negative value, then one character
// per cycle while the output is not stalled.
// One item at a time. Reset (rst_n, asynchronous, active low) idles and empties.
module signed_int_to_decimal_ascii
    import sitoda_pkg::*;
#(
    parameter int DATA_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    sitoda_in_if.sink       din,
    sitoda_out_if.source    dout
);

    localparam int NDIG   = dec_digits(DATA_BITS);
    localparam int BIT_CW = $clog2(DATA_BITS);
    localparam int DIG_CW = $clog2(NDIG);

    sitoda_state_t             state_reg, state_next;
    logic [BIT_CW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]         dig_cnt_reg, dig_cnt_next;
    logic                      neg_reg;
    logic                      out_valid_reg;
    logic [6:0]                char_reg, char_next;
    logic                      last_reg, last_next;
    logic                      load_out;
    logic                      out_free;
    sitoda_ctl_t               ctl;
    logic [DATA_BITS-1:0]      raw;
    logic [DATA_BITS-1:0]      mag;
    logic [DEC_DIGIT_BITS-1:0] top_digit;

    // most negative value wraps to 2^(DATA_BITS-1) unsigned, which is exact
    assign raw = din.value;
    assign mag = raw[DATA_BITS-1] ? DATA_BITS'(~raw + 1'b1) : raw;

    assign out_free  = !out_valid_reg || dout.ready;
    assign din.ready = (state_reg == ST_IDLE);

    sitoda_bcd #(
        .DATA_BITS (DATA_BITS)
    ) u_bcd (
        .clk       (clk),
        .ctl       (ctl),
        .mag       (mag),
        .top_digit (top_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            neg_reg <= raw[DATA_BITS-1];
        if (load_out)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        ctl          = '0;
        load_out     = 1'b0;
        char_next    = CHAR_ZERO + 7'(top_digit);
        last_next    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    ctl.load     = 1'b1;
                    bit_cnt_next = BIT_CW'(DATA_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctl.dabble = 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CW'(NDIG - 1);
                    state_next   = ST_SKIP;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keeping the units digit
                if (top_digit == '0 && dig_cnt_reg != '0)
                begin
                    ctl.dshift   = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    char_next  = CHAR_MINUS;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    last_next  = (dig_cnt_reg == '0);
                    ctl.dshift = 1'b1;
                    if (dig_cnt_reg == '0)
                        state_next = ST_IDLE;
                    else
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign dout.valid     = out_valid_reg;
    assign dout.char_code = char_reg;
    assign dout.last      = last_reg;

endmodule

[rtl/sitoda_chk.sv]
`include "signed_int_to_decimal_ascii_macros.svh"

module sitoda_chk
    import sitoda_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_char,
    input logic       out_last
);

    // a stalled beat stays put
    `SITODA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SITODA_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
                       $stable(out_char) && $stable(out_last))

    // one number at a time: no new value until the text is under way to its end
    `SITODA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `SITODA_ASSERT_IMP(a_busy_mid_text, out_valid && !out_last, !in_ready)

    // the sign is never the whole text
    `SITODA_ASSERT_IMP(a_minus_not_last, out_valid && out_char == CHAR_MINUS, !out_last)

endmodule

bind signed_int_to_decimal_ascii sitoda_chk u_sitoda_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_char  (dout.char_code),
    .out_last  (dout.last)
);

[tb/tb_signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
    import sitoda_pkg::*;

    localparam int DATA_BITS    = 32;
    localparam int RANDOM_ITEMS = 210;
    localparam int MAX_GAP      = 11;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
    } char_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    sitoda_in_if #(.DATA_BITS(DATA_BITS)) din_if ();
    sitoda_out_if                         dout_if ();

    signed_int_to_decimal_ascii #(
        .DATA_BITS (DATA_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic signed [DATA_BITS-1:0] values_to_send [$];
    char_beat_t                  text_expected [$];

    logic signed [DATA_BITS-1:0] corner_values [$] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
        32'sd99, 32'sd100, -32'sd101, 32'sd123456789, 32'sd999999999,
        32'sd1000000000, -32'sd1000000000, 32'sd1999999999, -32'sd2000000000,
        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sh5555_5555,
        32'shAAAA_AAAA, 32'sh0F0F_F0F0
    };

    bit in_taken, out_taken;
    bit in_quiet, out_quiet;
    int in_gap, out_gap;
    int errors, numbers_sent, chars_checked, minus_seen, longest_text;
    int text_len;
    int cycle_count;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Gap before the next beat; quiet stretches switch on and off now and then
    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 24) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void predict_text(input logic signed [DATA_BITS-1:0] v);
        logic [DATA_BITS:0] mag;
        int                 digs [$];
        char_beat_t         c;
        // one bit wider so the most negative value has a true magnitude
        mag = v[DATA_BITS-1] ? ({(DATA_BITS+1){1'b0}} - {v[DATA_BITS-1], v})
                             : {1'b0, v};
        do
        begin
            digs.push_front(int'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (v[DATA_BITS-1])
        begin
            c.char_code = CHAR_MINUS;
            c.last      = 1'b0;
            text_expected.push_back(c);
        end
        foreach (digs[i])
        begin
            c.char_code = CHAR_ZERO + 7'(digs[i]);
            c.last      = (i == digs.size() - 1);
            text_expected.push_back(c);
        end
    endfunction

    function automatic logic signed [DATA_BITS-1:0] random_value();
        int                          kind;
        int                          n;
        longint unsigned             span;
        longint unsigned             m;
        logic signed [DATA_BITS-1:0] r;
        kind = $urandom_range(0, 3);
        span = 1;
        case (kind)
            0: r = $urandom;
            1: r = $urandom_range(0, 999);
            2:
            begin
                n = $urandom_range(1, 10);
                repeat (n) span *= 10;
                m = {$urandom, $urandom} % span;
                m = m % 64'h8000_0000;
                r = m[DATA_BITS-1:0];
            end
            default:
            begin
                // around powers of ten, where the digit count changes
                n = $urandom_range(0, 9);
                repeat (n) span *= 10;
                m = span - 1 + $urandom_range(0, 2);
                r = m[DATA_BITS-1:0];
            end
        endcase
        if (kind != 0 && $urandom_range(0, 1))
            r = -r;
        return r;
    endfunction

    // Input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken || !din_if.valid)
            begin
                if (in_taken)
                begin
                    in_taken = 1'b0;
                    in_gap   = draw_gap(in_quiet);
                end
                if (in_gap > 0)
                begin
                    in_gap--;
                    din_if.valid <= 1'b0;
                end
                else if (values_to_send.size() > 0)
                begin
                    din_if.valid <= 1'b1;
                    din_if.value <= values_to_send.pop_front();
                end
                else
                    din_if.valid <= 1'b0;
            end
        end
    end

    // Output ready driver, one stall draw per character beat
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken || !dout_if.ready)
            begin
                if (out_taken)
                begin
                    out_taken = 1'b0;
                    out_gap   = draw_gap(out_quiet);
                end
                if (out_gap > 0)
                begin
                    out_gap--;
                    dout_if.ready <= 1'b0;
                end
                else
                    dout_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each input beat, checks each output beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din_if.valid && din_if.ready)
            begin
                in_taken = 1'b1;
                numbers_sent++;
                predict_text(din_if.value);
            end
            if (dout_if.valid && dout_if.ready)
            begin
                out_taken = 1'b1;
                chars_checked++;
                text_len++;
                if (dout_if.char_code == CHAR_MINUS)
                    minus_seen++;
                if (dout_if.last === 1'b1)
                begin
                    if (text_len > longest_text)
                        longest_text = text_len;
                    text_len = 0;
                end
                if (text_expected.size() == 0)
                    report_mismatch($sformatf("unexpected character %0d last %b",
                                              dout_if.char_code, dout_if.last));
                else
                begin
                    automatic char_beat_t want = text_expected.pop_front();
                    if (dout_if.char_code !== want.char_code)
                        report_mismatch($sformatf("char_code %0d, expected %0d",
                                                  dout_if.char_code, want.char_code));
                    if (dout_if.last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b (char %0d)",
                                                  dout_if.last, want.last,
                                                  want.char_code));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d characters outstanding",
                     cycle_count, text_expected.size());
            $display("signed_int_to_decimal_ascii verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        din_if.valid  = 1'b0;
        din_if.value  = '0;
        dout_if.ready = 1'b0;

        foreach (corner_values[i])
            values_to_send.push_back(corner_values[i]);
        repeat (RANDOM_ITEMS)
            values_to_send.push_back(random_value());

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (values_to_send.size() != 0 || din_if.valid)
            @(posedge clk);
        while (text_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (text_expected.size() != 0)
            report_mismatch("expected text left over");
        $display("%0d integers converted, %0d characters checked in %0d cycles",
                 numbers_sent, chars_checked, cycle_count);
        $display("%0d minus signs seen, longest text %0d characters, %0d mismatches",
                 minus_seen, longest_text, errors);
        if (errors == 0)
            $display("signed_int_to_decimal_ascii verification clean");
        else
            $display("signed_int_to_decimal_ascii verification failed");
        $finish;
    end

endmodule
